FILE: hdl/xsfb_pkg.sv
// Shared constants, types and helper functions for the XOR sprite framebuffer.
`timescale 1ns / 1ps
`default_nettype none
package xsfb_pkg;

  localparam int WIDTH       = 64;
  localparam int HEIGHT      = 32;
  localparam int PIX_W       = 64;
  localparam int SPRITE_BITS = 8;
  localparam int COORD_W     = 8;
  localparam int COORD_N     = 1 << COORD_W;
  localparam int COL_W       = $clog2(WIDTH);
  localparam int ROW_W       = $clog2(HEIGHT);

  typedef enum logic [1:0] {
    ACT_DRAW  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_ACK   = 2'd3
  } action_t;

  typedef logic [COL_W-1:0] col_lut_t [COORD_N];
  typedef logic [ROW_W-1:0] row_lut_t [COORD_N];

  typedef struct packed {
    logic             rd_en;
    logic [ROW_W-1:0] rd_addr;
    logic             wr_en;
    logic [ROW_W-1:0] wr_addr;
    logic [WIDTH-1:0] wr_data;
    logic             clr_all;
  } mem_req_t;

  function automatic col_lut_t build_col_lut();
    col_lut_t lut;
    for (int i = 0; i < COORD_N; i++) begin
      lut[i] = COL_W'(i % WIDTH);
    end
    return lut;
  endfunction

  function automatic row_lut_t build_row_lut();
    row_lut_t lut;
    for (int i = 0; i < COORD_N; i++) begin
      lut[i] = ROW_W'(i % HEIGHT);
    end
    return lut;
  endfunction

  localparam col_lut_t COL_LUT = build_col_lut();
  localparam row_lut_t ROW_LUT = build_row_lut();

  // Sprite row placed at column base, msb leftmost, wrapping at WIDTH.
  function automatic logic [WIDTH-1:0] sprite_mask(logic [COL_W-1:0] base,
                                                   logic [SPRITE_BITS-1:0] spr);
    logic [WIDTH-1:0] m;
    logic [COL_W:0]   c;
    m = '0;
    for (int k = 0; k < SPRITE_BITS; k++) begin
      c = {1'b0, base} + (COL_W + 1)'(k);
      if (c >= (COL_W + 1)'(WIDTH)) begin
        c = c - (COL_W + 1)'(WIDTH);
      end
      if (spr[SPRITE_BITS-1-k]) begin
        m[c[COL_W-1:0]] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/xsfb_row_mem.sv
// Row memory of the framebuffer with per-row valid bits; invalid rows read as zero.
`timescale 1ns / 1ps
`default_nettype none
module xsfb_row_mem (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire xsfb_pkg::mem_req_t         req,
  output logic [xsfb_pkg::WIDTH-1:0]      rd_row
);
  import xsfb_pkg::*;

  logic [WIDTH-1:0]  mem [HEIGHT];
  logic [HEIGHT-1:0] vld_r;
  logic [WIDTH-1:0]  rd_data_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
      rd_vld_r  <= vld_r[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.clr_all) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_row = rd_vld_r ? rd_data_r : '0;

endmodule
`default_nettype wire

FILE: hdl/xor_sprite_framebuffer.sv
// Top level of the XOR sprite framebuffer.
//
// Input channel (in_valid/in_ready) takes one word per item: action, pos_x,
// pos_y, sprite_row. Output channel (out_valid/out_ready) returns one word per
// item: collision, row_pixels (row pos_y mod HEIGHT after the action) and
// draw_pending.
// Each item passes through ST_IDLE and ST_EXEC: the accept edge issues a read of
// the row memory; the edge that leaves ST_EXEC does the read-modify-write and
// loads the output register. The read result is registered in the row memory,
// and no word is taken while an item executes. A clear drops all per-row valid
// bits at once, so it takes the same path as any other item.
// A new item is taken while a finished result waits in the output register;
// if the receiver still stalls when the next item is ready to finish, that
// item holds in ST_EXEC until the output register frees up.
// Synchronous reset (rst_n low) empties the screen, clears draw_pending and
// drops out_valid.
`timescale 1ns / 1ps
`default_nettype none
module xor_sprite_framebuffer (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          in_action,
  input  wire logic [xsfb_pkg::COORD_W-1:0]        in_pos_x,
  input  wire logic [xsfb_pkg::COORD_W-1:0]        in_pos_y,
  input  wire logic [xsfb_pkg::SPRITE_BITS-1:0]    in_sprite_row,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_collision,
  output logic [xsfb_pkg::PIX_W-1:0]               out_row_pixels,
  output logic                                     out_draw_pending
);
  import xsfb_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t                 state_r;
  action_t                act_r;
  logic [ROW_W-1:0]       row_r;
  logic [COL_W-1:0]       col_r;
  logic [SPRITE_BITS-1:0] spr_r;
  logic                   flag_r;
  logic                   out_valid_r;
  logic                   coll_r;
  logic [PIX_W-1:0]       pix_r;

  mem_req_t               req;
  logic [WIDTH-1:0]       old_row;
  logic [WIDTH-1:0]       pat;
  logic [WIDTH-1:0]       new_row;
  logic                   accept;
  logic                   done;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign done     = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  assign pat = sprite_mask(col_r, spr_r);

  always_comb begin
    new_row = old_row;
    unique case (act_r)
      ACT_DRAW:  new_row = old_row ^ pat;
      ACT_CLEAR: new_row = '0;
      ACT_READ:  new_row = old_row;
      ACT_ACK:   new_row = old_row;
      default:   new_row = old_row;
    endcase
  end

  always_comb begin
    req         = '0;
    req.rd_en   = accept;
    req.rd_addr = ROW_LUT[in_pos_y];
    req.wr_en   = done && (act_r == ACT_DRAW);
    req.wr_addr = row_r;
    req.wr_data = new_row;
    req.clr_all = done && (act_r == ACT_CLEAR);
  end

  xsfb_row_mem u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .rd_row (old_row)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_EXEC;
            act_r   <= action_t'(in_action);
            row_r   <= ROW_LUT[in_pos_y];
            col_r   <= COL_LUT[in_pos_x];
            spr_r   <= in_sprite_row;
          end
        end
        ST_EXEC: begin
          if (done) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            coll_r      <= (act_r == ACT_DRAW) && |(old_row & pat);
            pix_r       <= PIX_W'(new_row);
            priority case (act_r)
              ACT_DRAW, ACT_CLEAR: flag_r <= 1'b1;
              ACT_ACK:             flag_r <= 1'b0;
              default:             flag_r <= flag_r;
            endcase
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_collision    = coll_r;
  assign out_row_pixels   = pix_r;
  assign out_draw_pending = flag_r;

`ifndef SYNTH
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    done && (act_r == ACT_CLEAR) |=> (out_row_pixels == '0) && out_draw_pending)
    else $error("clear did not return an empty row with draw pending");

  a_ack_drops: assert property (@(posedge clk) disable iff (!rst_n)
    done && (act_r == ACT_ACK) |=> !out_draw_pending)
    else $error("acknowledge left draw pending set");

  a_coll_draw: assert property (@(posedge clk) disable iff (!rst_n)
    done && (act_r != ACT_DRAW) |=> !out_collision)
    else $error("collision reported for a non-draw item");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC) && !in_ready)
    else $error("accepted item did not enter execution");
`endif

endmodule
`default_nettype wire
